### hdl/ddh_pkg.sv
// Shared types and constants for the double-hash key-value table.
// Holds operation, status and sequencer codes and the memory control group.
// No dependencies.
package ddh_pkg;

   localparam int DEF_TABLE_SIZE = 1021;
   localparam int DEF_KEY_BITS   = 32;
   localparam int DEF_VALUE_BITS = 32;
   localparam int COUNT_OUT_BITS = 10;
   localparam int DIGIT_BITS     = 4;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_HIT      = 3'd3,
      ST_MISS     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_START,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

   typedef struct packed {
      logic       stop;
      logic       wr;
      logic       inc;
      logic       dec;
      status_type status;
   } decision_type;

endpackage

### hdl/ddh_mod_unit.sv
// Shared remainder unit: key mod TABLE_SIZE and key mod (TABLE_SIZE-2), DIGIT_BITS per cycle.
// Depends on ddh_pkg.
module ddh_mod_unit #(
   parameter int TABLE_SIZE = ddh_pkg::DEF_TABLE_SIZE,
   parameter int KEY_BITS   = ddh_pkg::DEF_KEY_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [KEY_BITS-1:0]           key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] rem_first,
   output logic [$clog2(TABLE_SIZE)-1:0] rem_step
);
   localparam int RW     = $clog2(TABLE_SIZE);
   localparam int DIGITS = (KEY_BITS + ddh_pkg::DIGIT_BITS - 1) / ddh_pkg::DIGIT_BITS;
   localparam int PADW   = DIGITS * ddh_pkg::DIGIT_BITS;
   localparam int DCW    = $clog2(DIGITS + 1);
   localparam logic [RW:0] MOD_A = (RW+1)'(TABLE_SIZE);
   localparam logic [RW:0] MOD_B = (RW+1)'(TABLE_SIZE - 2);

   logic [PADW-1:0] shift_ff, shift_in;
   logic [RW-1:0]   rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [DCW-1:0]  cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      logic [RW:0]   ta;
      logic [RW:0]   tb;
      logic [RW-1:0] ra;
      logic [RW-1:0] rb;
      ra = rem_a_ff;
      rb = rem_b_ff;
      for (int i = 0; i < ddh_pkg::DIGIT_BITS; i++) begin
         ta = {ra, shift_ff[PADW-1-i]};
         tb = {rb, shift_ff[PADW-1-i]};
         if (ta >= MOD_A) begin
            ta = ta - MOD_A;
         end
         if (tb >= MOD_B) begin
            tb = tb - MOD_B;
         end
         ra = ta[RW-1:0];
         rb = tb[RW-1:0];
      end
      shift_in = shift_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = PADW'(key);
         rem_a_in = '0;
         rem_b_in = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << ddh_pkg::DIGIT_BITS;
         rem_a_in = ra;
         rem_b_in = rb;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == DCW'(DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign rem_first = rem_a_ff;
   assign rem_step  = rem_b_ff;

endmodule

### hdl/ddh_slot_ram.sv
// Single-port slot memory: used, active, key and value per slot, registered read.
// Depends on ddh_pkg.
module ddh_slot_ram #(
   parameter int TABLE_SIZE = ddh_pkg::DEF_TABLE_SIZE,
   parameter int KEY_BITS   = ddh_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = ddh_pkg::DEF_VALUE_BITS
) (
   input  logic                          clock,
   input  ddh_pkg::ram_ctl_type          ctl,
   input  logic [$clog2(TABLE_SIZE)-1:0] addr,
   input  logic                          wr_used,
   input  logic                          wr_active,
   input  logic [KEY_BITS-1:0]           wr_key,
   input  logic [VALUE_BITS-1:0]         wr_value,
   output logic                          rd_used,
   output logic                          rd_active,
   output logic [KEY_BITS-1:0]           rd_key,
   output logic [VALUE_BITS-1:0]         rd_value
);
   localparam int W = 2 + KEY_BITS + VALUE_BITS;

   logic [W-1:0] slot_mem_ff [TABLE_SIZE];
   logic [W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         slot_mem_ff[addr] <= {wr_used, wr_active, wr_key, wr_value};
      end
      if (ctl.rd_en) begin
         rd_ff <= slot_mem_ff[addr];
      end
   end

   assign {rd_used, rd_active, rd_key, rd_value} = rd_ff;

endmodule

### hdl/double_hash_key_value_table_core.sv
// Top level of the double-hash key-value table: sequencer, probe datapath, result register.
// Depends on ddh_pkg, ddh_mod_unit and ddh_slot_ram.
//
// Usage: the request channel (req_valid, req_stall, operation, key, value) carries one
// operation per item: insert or update, remove, or lookup. Each item gives exactly one
// item on the response channel (rsp_valid, rsp_stall, status, found_value, entry_count).
// An item is taken when valid is high and stall is low.
// Sequence: one item at a time. After acceptance the remainder unit computes the first
// slot and the probe step, a start state checks the early outcomes, then each probe
// reads the slot on the single memory port, then checks it and possibly writes it
// back. req_stall drops again in the same cycle that the response is loaded.
// Reset: a clearing pass writes every slot to zero, one slot per cycle, over all
// TABLE_SIZE slots (1021 by default); req_stall stays high until it ends.
// Stall: the response register holds its item while rsp_stall is high; the next item
// may be accepted and processed meanwhile and waits for the register to free up.
module double_hash_key_value_table_core #(
   parameter int TABLE_SIZE = ddh_pkg::DEF_TABLE_SIZE,
   parameter int KEY_BITS   = ddh_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS = ddh_pkg::DEF_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_operation,
   input  logic [KEY_BITS-1:0]                req_key,
   input  logic [VALUE_BITS-1:0]              req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_status,
   output logic [VALUE_BITS-1:0]              rsp_found_value,
   output logic [ddh_pkg::COUNT_OUT_BITS-1:0] rsp_entry_count
);
   localparam int RW = $clog2(TABLE_SIZE);
   localparam int CW = $clog2(TABLE_SIZE + 1);

   ddh_pkg::state_type   state_ff, state_in;
   ddh_pkg::op_type      op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [RW-1:0]         clr_ff, clr_in;
   logic [RW-1:0]         idx_ff, idx_in, step_ff, step_in;
   logic [CW-1:0]         n_ff, n_in, count_ff, count_in;
   ddh_pkg::status_type  res_status_ff, res_status_in;
   logic [VALUE_BITS-1:0] res_found_ff, res_found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] rsp_found_ff, rsp_found_in;
   logic [ddh_pkg::COUNT_OUT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic                  hash_start, hash_done;
   logic [RW-1:0]         rem_first, rem_step;
   ddh_pkg::ram_ctl_type ram_ctl;
   logic [RW-1:0]         ram_addr;
   logic                  wr_used, wr_active;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_value;
   logic                  rd_used, rd_active;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;

   ddh_pkg::decision_type start_dec, probe_dec;
   logic                  clr_last, accept, rsp_free, key_eq, last_probe;
   logic [RW:0]           idx_sum;
   logic [RW-1:0]         idx_next;
   logic [CW+ddh_pkg::COUNT_OUT_BITS-1:0] count_wide;

   ddh_mod_unit #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (hash_start),
      .key       (req_key),
      .done      (hash_done),
      .rem_first (rem_first),
      .rem_step  (rem_step)
   );

   ddh_slot_ram #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_ram (
      .clock     (clock),
      .ctl       (ram_ctl),
      .addr      (ram_addr),
      .wr_used   (wr_used),
      .wr_active (wr_active),
      .wr_key    (wr_key),
      .wr_value  (wr_value),
      .rd_used   (rd_used),
      .rd_active (rd_active),
      .rd_key    (rd_key),
      .rd_value  (rd_value)
   );

   assign clr_last   = (clr_ff == RW'(TABLE_SIZE - 1));
   assign accept     = (state_ff == ddh_pkg::S_IDLE) && req_valid;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign key_eq     = (rd_key == key_ff);
   assign last_probe = (n_ff == CW'(TABLE_SIZE - 1));
   assign idx_sum    = {1'b0, idx_ff} + {1'b0, step_ff};
   assign idx_next   = (idx_sum >= (RW+1)'(TABLE_SIZE)) ?
                       RW'(idx_sum - (RW+1)'(TABLE_SIZE)) : idx_sum[RW-1:0];
   assign count_wide = (CW+ddh_pkg::COUNT_OUT_BITS)'(count_ff);

   // early outcomes before any probe
   always_comb begin
      start_dec = '{stop: 1'b0, wr: 1'b0, inc: 1'b0, dec: 1'b0,
                    status: ddh_pkg::ST_MISS};
      unique case (op_ff)
         ddh_pkg::OP_INSERT: begin
            if (count_ff >= CW'(TABLE_SIZE)) begin
               start_dec.stop   = 1'b1;
               start_dec.status = ddh_pkg::ST_FULL;
            end
         end
         ddh_pkg::OP_REMOVE: begin
            start_dec.stop = 1'b0;
         end
         ddh_pkg::OP_LOOKUP: begin
            start_dec.stop = (count_ff == '0);
         end
         default: begin
            start_dec.stop = 1'b1;
         end
      endcase
   end

   // outcome of one probed slot
   always_comb begin
      probe_dec = '{stop: 1'b0, wr: 1'b0, inc: 1'b0, dec: 1'b0,
                    status: ddh_pkg::ST_MISS};
      unique case (op_ff)
         ddh_pkg::OP_INSERT: begin
            priority if (rd_active && key_eq) begin
               probe_dec.stop   = 1'b1;
               probe_dec.wr     = 1'b1;
               probe_dec.status = ddh_pkg::ST_UPDATED;
            end else if (!rd_active) begin
               probe_dec.stop   = 1'b1;
               probe_dec.wr     = 1'b1;
               probe_dec.inc    = 1'b1;
               probe_dec.status = ddh_pkg::ST_INSERTED;
            end else if (last_probe) begin
               probe_dec.stop   = 1'b1;
               probe_dec.status = ddh_pkg::ST_FULL;
            end
         end
         ddh_pkg::OP_REMOVE: begin
            priority if (!rd_used) begin
               probe_dec.stop = 1'b1;
            end else if (key_eq) begin
               probe_dec.stop = 1'b1;
               if (rd_active) begin
                  probe_dec.wr     = 1'b1;
                  probe_dec.dec    = 1'b1;
                  probe_dec.status = ddh_pkg::ST_HIT;
               end
            end else if (last_probe) begin
               probe_dec.stop = 1'b1;
            end
         end
         ddh_pkg::OP_LOOKUP: begin
            priority if (key_eq) begin
               probe_dec.stop = 1'b1;
               if (rd_active) begin
                  probe_dec.status = ddh_pkg::ST_HIT;
               end
            end else if (!rd_used || last_probe) begin
               probe_dec.stop = 1'b1;
            end
         end
         default: begin
            probe_dec.stop = 1'b1;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ddh_pkg::S_CLEAR: begin
            if (clr_last) begin
               state_in = ddh_pkg::S_IDLE;
            end
         end
         ddh_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ddh_pkg::S_HASH;
            end
         end
         ddh_pkg::S_HASH: begin
            if (hash_done) begin
               state_in = ddh_pkg::S_START;
            end
         end
         ddh_pkg::S_START: begin
            state_in = start_dec.stop ? ddh_pkg::S_FINISH : ddh_pkg::S_PROBE_RD;
         end
         ddh_pkg::S_PROBE_RD: begin
            state_in = ddh_pkg::S_PROBE_CHK;
         end
         ddh_pkg::S_PROBE_CHK: begin
            state_in = probe_dec.stop ? ddh_pkg::S_FINISH : ddh_pkg::S_PROBE_RD;
         end
         ddh_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = ddh_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ddh_pkg::S_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall  = (state_ff != ddh_pkg::S_IDLE);
      hash_start = accept;
      ram_ctl    = '{rd_en: 1'b0, wr_en: 1'b0};
      ram_addr   = idx_ff;
      wr_used    = 1'b1;
      wr_active  = (op_ff != ddh_pkg::OP_REMOVE);
      wr_key     = key_ff;
      wr_value   = (op_ff == ddh_pkg::OP_REMOVE) ? rd_value : val_ff;
      unique case (state_ff)
         ddh_pkg::S_CLEAR: begin
            ram_ctl.wr_en = 1'b1;
            ram_addr      = clr_ff;
            wr_used       = 1'b0;
            wr_active     = 1'b0;
            wr_key        = '0;
            wr_value      = '0;
         end
         ddh_pkg::S_PROBE_RD: begin
            ram_ctl.rd_en = 1'b1;
         end
         ddh_pkg::S_PROBE_CHK: begin
            ram_ctl.wr_en = probe_dec.wr;
         end
         default: begin
            ram_ctl = '{rd_en: 1'b0, wr_en: 1'b0};
         end
      endcase
   end

   // datapath
   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      n_in          = n_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ddh_pkg::S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         ddh_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in  = ddh_pkg::op_type'(req_operation);
               key_in = req_key;
               val_in = req_value;
            end
         end
         ddh_pkg::S_HASH: begin
            idx_in  = rem_first;
            step_in = rem_step + 1'b1;
            n_in    = '0;
         end
         ddh_pkg::S_START: begin
            res_status_in = start_dec.status;
            res_found_in  = '0;
         end
         ddh_pkg::S_PROBE_RD: begin
            idx_in = idx_ff;
         end
         ddh_pkg::S_PROBE_CHK: begin
            res_status_in = probe_dec.status;
            res_found_in  = (probe_dec.status == ddh_pkg::ST_HIT) ? rd_value : '0;
            if (probe_dec.inc) begin
               count_in = count_ff + 1'b1;
            end else if (probe_dec.dec && (count_ff != '0)) begin
               count_in = count_ff - 1'b1;
            end
            if (!probe_dec.stop) begin
               idx_in = idx_next;
               n_in   = n_ff + 1'b1;
            end
         end
         ddh_pkg::S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_count_in  = count_wide[ddh_pkg::COUNT_OUT_BITS-1:0];
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= ddh_pkg::S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_SIZE))
      else $error("active count beyond table size");

   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ddh_pkg::S_FINISH))
      else $error("response loaded outside finish state");

   a_ram_single_port : assert property (@(posedge clock) disable iff (reset)
      !(ram_ctl.rd_en && ram_ctl.wr_en))
      else $error("read and write on the slot memory together");

   a_probe_bounds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ddh_pkg::S_PROBE_CHK) |->
         ((idx_ff < RW'(TABLE_SIZE)) && (n_ff < CW'(TABLE_SIZE))))
      else $error("probe index or probe count out of range");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ddh_pkg::S_PROBE_CHK) |=> $stable(count_ff))
      else $error("active count changed outside a probe check");

endmodule
